FILE: rtl/srba_pkg.sv
`timescale 1ns / 1ps

package srba_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int DELTA_W     = 16;
  localparam int PERIOD_W    = 9;
  localparam int SHIFT_W     = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;

  localparam cfg_idx_t REG_MOVE_DELTA    = 2'd0;
  localparam cfg_idx_t REG_STABLE_PERIOD = 2'd1;
  localparam cfg_idx_t REG_AVERAGE_SHIFT = 2'd2;

  localparam logic [DELTA_W-1:0]  DELTA_RESET  = 16'd16;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 9'd16;
  localparam logic [SHIFT_W-1:0]  SHIFT_RESET  = 4'd4;

endpackage

FILE: rtl/stable_reading_block_averager.sv
`timescale 1ns / 1ps

// Stable-reading block averager. Each accepted sample yields exactly one result beat:
// while it sits in the input register the reference compare, accumulate, count and
// shift/saturate update the state and load the result register, where the result then
// waits for its beat. A new sample can be taken every cycle; throughput is one per
// cycle, limited only by out_ready back-pressure, which reaches in_ready combinationally.
// A sample further than move_delta from the reference restarts accumulation (on_move);
// after stable_period stable samples the sum is shifted right by average_shift,
// saturated to signed 16 bits and reported with new_average. Period 0 acts as 1 and
// periods above MAX_PERIOD act as MAX_PERIOD. Configuration writes are always accepted
// (cfg_ready is tied high) and must only be made while the block is idle.
module stable_reading_block_averager #(
  parameter int MAX_PERIOD = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  srba_pkg::sample_t                   in_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output srba_pkg::sample_t                   out_filtered_value,
  output logic                                out_new_average,
  output logic                                out_on_move,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  srba_pkg::cfg_idx_t                  cfg_index,
  input  logic [srba_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import srba_pkg::*;

  localparam int CNT_W = $clog2(MAX_PERIOD + 1);
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_PERIOD);
  localparam int DIF_W = SAMPLE_BITS + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PERIOD);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

  // configuration
  logic [DELTA_W-1:0]  move_delta_r;
  logic [PERIOD_W-1:0] stable_period_r;
  logic [SHIFT_W-1:0]  average_shift_r;

  // input stage
  logic    s1_valid_r;
  sample_t s1_sample_r;
  logic    s1_adv;

  // state
  sample_t                 ref_r, ref_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  sample_t                 last_avg_r, last_avg_nxt;

  // result stage
  logic out_valid_r;
  logic new_avg_r, new_avg_nxt;
  logic on_move_r, on_move_nxt;

  // datapath
  logic signed [DIF_W-1:0] diff;
  logic [DIF_W-1:0]        abs_diff;
  logic                    moved;
  logic                    period_over;
  logic [CNT_W-1:0]        period_eff;
  logic [CNT_W-1:0]        count_inc;
  logic signed [SUM_W-1:0] sum_acc;
  logic signed [SUM_W-1:0] sum_shr;
  sample_t                 avg_sat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_delta_r    <= DELTA_RESET;
      stable_period_r <= PERIOD_RESET;
      average_shift_r <= SHIFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MOVE_DELTA:    move_delta_r    <= cfg_data[DELTA_W-1:0];
        REG_STABLE_PERIOD: stable_period_r <= cfg_data[PERIOD_W-1:0];
        REG_AVERAGE_SHIFT: average_shift_r <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // the result slot is free or drains this cycle
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample_r <= in_sample;
    end
  end

  always_comb begin
    diff        = DIF_W'(ref_r) - DIF_W'(s1_sample_r);
    abs_diff    = diff[DIF_W-1] ? $unsigned(-diff) : $unsigned(diff);
    moved       = abs_diff > DIF_W'(move_delta_r);

    period_over = 32'(stable_period_r) > 32'(MAX_PERIOD);
    if (stable_period_r == '0) begin
      period_eff = CNT_ONE;
    end else if (period_over) begin
      period_eff = CNT_MAX;
    end else begin
      period_eff = CNT_W'(stable_period_r);
    end

    count_inc = count_r + CNT_ONE;
    sum_acc   = sum_r + SUM_W'(s1_sample_r);
    sum_shr   = sum_acc >>> average_shift_r;
    if (sum_shr > SAT_HI) begin
      avg_sat = sample_t'(SAT_HI);
    end else if (sum_shr < SAT_LO) begin
      avg_sat = sample_t'(SAT_LO);
    end else begin
      avg_sat = sample_t'(sum_shr);
    end

    ref_nxt      = ref_r;
    count_nxt    = count_inc;
    sum_nxt      = sum_acc;
    last_avg_nxt = last_avg_r;
    new_avg_nxt  = 1'b0;
    on_move_nxt  = 1'b0;
    if (moved) begin
      on_move_nxt = 1'b1;
      ref_nxt     = s1_sample_r;
      count_nxt   = '0;
      sum_nxt     = '0;
    end else if (count_inc >= period_eff) begin
      new_avg_nxt  = 1'b1;
      last_avg_nxt = avg_sat;
      ref_nxt      = avg_sat;
      count_nxt    = '0;
      sum_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r       <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      last_avg_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        ref_r      <= ref_nxt;
        count_r    <= count_nxt;
        sum_r      <= sum_nxt;
        last_avg_r <= last_avg_nxt;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      new_avg_r <= new_avg_nxt;
      on_move_r <= on_move_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_value = last_avg_r;
  assign out_new_average    = new_avg_r;
  assign out_on_move        = on_move_r;

endmodule

FILE: sim/tb_stable_reading_block_averager.sv
`timescale 1ns / 1ps

module tb_stable_reading_block_averager;
  import srba_pkg::*;

  localparam int MAX_SPAN    = 256;
  localparam int STALL_LIMIT = 1000;
  localparam int LONG_HOLD   = 150;
  localparam cfg_idx_t REG_UNUSED = 2'd3;

  typedef struct packed {
    sample_t level;
    logic    fresh;
    logic    moved;
  } reading_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  sample_t in_sample;
  logic out_valid;
  logic out_ready;
  sample_t out_filtered_value;
  logic out_new_average;
  logic out_on_move;
  logic cfg_valid;
  logic cfg_ready;
  cfg_idx_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  stable_reading_block_averager #(
    .MAX_PERIOD(MAX_SPAN)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_sample(in_sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_filtered_value(out_filtered_value),
    .out_new_average(out_new_average),
    .out_on_move(out_on_move),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // averager state as the block should hold it
  logic [DELTA_W-1:0]  delta_reg;
  logic [PERIOD_W-1:0] period_reg;
  logic [SHIFT_W-1:0]  shift_reg;
  sample_t             ref_level;
  logic [8:0]          tally;
  logic signed [23:0]  acc;
  sample_t             last_avg;

  sample_t         feed[$];
  reading_result_t pending_averages[$];

  int   failures = 0;
  int   idle_cycles = 0;
  logic in_taken = 1'b0;
  logic quiet = 1'b0;
  int   send_gap = 0;
  int   recv_gap = 0;
  int   hold_requests = 0;
  int   holds_done = 0;
  int   hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic advance_averager(input sample_t s);
    logic signed [16:0] gap;
    logic [16:0]        mag;
    logic [8:0]         span;
    int                 full;
    reading_result_t    r;
    gap = ref_level - s;
    mag = (gap < 0) ? 17'(-gap) : 17'(gap);
    span = (period_reg == 0) ? 9'd1 : ((period_reg > MAX_SPAN) ? 9'(MAX_SPAN) : period_reg);
    r.fresh = 1'b0;
    r.moved = 1'b0;
    if (mag > {1'b0, delta_reg}) begin
      r.moved = 1'b1;
      ref_level = s;
      tally = '0;
      acc = '0;
    end else begin
      acc = acc + s;
      tally = tally + 9'd1;
      if (tally >= span) begin
        full = int'(acc >>> shift_reg);
        if (full > 32767) full = 32767;
        else if (full < -32768) full = -32768;
        last_avg = sample_t'(full);
        ref_level = last_avg;
        r.fresh = 1'b1;
        tally = '0;
        acc = '0;
      end
    end
    r.level = last_avg;
    pending_averages.push_back(r);
  endtask

  // sampling, checking and watchdog
  always @(posedge clk) begin
    reading_result_t want;
    if (rst_n) begin
      in_taken = in_valid && in_ready;
      if (in_taken) advance_averager(in_sample);
      if (out_valid && out_ready) begin
        if (pending_averages.size() == 0) begin
          $error("result beat with nothing expected");
          failures++;
        end else begin
          want = pending_averages.pop_front();
          if (out_filtered_value !== want.level) begin
            $error("filtered_value: expected %0d, got %0d", want.level, out_filtered_value);
            failures++;
          end
          if (out_new_average !== want.fresh) begin
            $error("new_average: expected %0b, got %0b", want.fresh, out_new_average);
            failures++;
          end
          if (out_on_move !== want.moved) begin
            $error("on_move: expected %0b, got %0b", want.moved, out_on_move);
            failures++;
          end
        end
      end
      if (in_taken || (out_valid && out_ready) || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL stable_reading_block_averager");
        $finish;
      end
    end
  end

  // sample driver
  always @(negedge clk) begin
    if (in_valid && !in_taken) begin
      // beat still waiting, hold it
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (feed.size() > 0) begin
      in_valid <= 1'b1;
      in_sample <= feed.pop_front();
      if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 8);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (holds_done != hold_requests) begin
      holds_done++;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 7) == 0) recv_gap = $urandom_range(1, 8);
    end
  end

  task automatic wait_drained();
    while (feed.size() != 0 || in_valid || pending_averages.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MOVE_DELTA:    delta_reg = value[DELTA_W-1:0];
      REG_STABLE_PERIOD: period_reg = value[PERIOD_W-1:0];
      REG_AVERAGE_SHIFT: shift_reg = value[SHIFT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic queue_readings(input int n);
    int left;
    int run;
    int centre;
    int amp;
    int v;
    int span;
    left = n;
    span = (period_reg == 0) ? 1 : ((period_reg > MAX_SPAN) ? MAX_SPAN : int'(period_reg));
    amp = int'(delta_reg);
    while (left > 0) begin
      if ($urandom_range(0, 7) == 0) centre = $urandom_range(0, 1) ? 32767 : -32768;
      else centre = int'(sample_t'($urandom));
      run = $urandom_range(1, 2 * span + 2);
      if (run > left) run = left;
      repeat (run) begin
        case ($urandom_range(0, 9))
          0: v = int'(sample_t'($urandom));
          1: v = $urandom_range(0, 1) ? centre + amp : centre - amp;
          2: v = centre + amp + 1;
          default: v = centre + int'($urandom_range(0, 2 * amp)) - amp;
        endcase
        if (v > 32767) v = 32767;
        else if (v < -32768) v = -32768;
        feed.push_back(sample_t'(v));
      end
      left -= run;
    end
  endtask

  task automatic run_phase(input logic [15:0] d_delta, input logic [15:0] d_period,
                           input logic [15:0] d_shift, input int n);
    wait_drained();
    write_reg(REG_MOVE_DELTA, d_delta);
    write_reg(REG_STABLE_PERIOD, d_period);
    write_reg(REG_AVERAGE_SHIFT, d_shift);
    @(negedge clk);
    cfg_valid <= 1'b0;
    queue_readings(n);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_MOVE_DELTA;
    cfg_data = '0;
    delta_reg = DELTA_RESET;
    period_reg = PERIOD_RESET;
    shift_reg = SHIFT_RESET;
    ref_level = '0;
    tally = '0;
    acc = '0;
    last_avg = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: difference equal to delta stays stable, one more moves
    feed.push_back(16'sd0);
    feed.push_back(16'sd16);
    feed.push_back(-16'sd16);
    feed.push_back(16'sd17);
    feed.push_back(16'sd32767);
    feed.push_back(-16'sd32768);
    feed.push_back(sample_t'(16'h5555));
    feed.push_back(sample_t'(16'hAAAA));

    // short periods with no shift drive the average into saturation
    wait_drained();
    write_reg(REG_MOVE_DELTA, 16'hFFFF);
    write_reg(REG_STABLE_PERIOD, 16'hFE02);
    write_reg(REG_AVERAGE_SHIFT, 16'h0000);
    @(negedge clk);
    cfg_valid <= 1'b0;
    feed.push_back(16'sd32767);
    feed.push_back(16'sd32767);
    feed.push_back(-16'sd32768);
    feed.push_back(-16'sd32768);

    // period of zero behaves as one; negative averages round downwards
    wait_drained();
    write_reg(REG_STABLE_PERIOD, 16'h0000);
    write_reg(REG_AVERAGE_SHIFT, 16'hFFF1);
    write_reg(REG_UNUSED, 16'h1234);
    @(negedge clk);
    cfg_valid <= 1'b0;
    feed.push_back(-16'sd3);
    feed.push_back(16'sd5);
    feed.push_back(-16'sd1);

    run_phase(16'd16, 16'd16, 16'd4, 130);
    hold_requests++;
    run_phase(16'd0, 16'd1, 16'd0, 100);
    run_phase(16'hFFFF, 16'h0100, 16'd8, 300);
    run_phase(16'd300, 16'd8, 16'd3, 130);
    run_phase(16'd2000, 16'd4, 16'd2, 100);
    run_phase(16'd100, 16'h01FF, 16'd15, 120);
    repeat (4) begin
      run_phase(16'($urandom), {7'($urandom), 9'($urandom_range(0, 40))}, 16'($urandom), 100);
    end
    wait_drained();
    quiet = 1'b1;
    run_phase(16'd50, 16'd3, 16'd9, 150);

    wait_drained();
    repeat (10) @(posedge clk);
    if (failures == 0 && pending_averages.size() == 0) begin
      $display("PASS stable_reading_block_averager");
    end else begin
      $display("FAIL stable_reading_block_averager");
    end
    $finish;
  end

endmodule
